// File: src/plc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants for the piecewise linear calibrator.
// ----------------------------------------------------------------------------
package plc_pkg;

	// evaluation sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_LOW,
		S_HIGH,
		S_SCAN,
		S_RA,
		S_RB,
		S_MUL0,
		S_MUL1,
		S_DIV,
		S_SUM,
		S_OUT
	} plc_state_t;

	// item kinds on tuser
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_PASS = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;
	localparam logic [1:0] ST_ZERO = 2'd3;

	// register index decoded from paddr[2]
	localparam logic REG_POINTS_IN_USE = 1'b0;

	// operand widths of the segment arithmetic
	localparam int MAG_W  = 33;
	localparam int PROD_W = 66;
	localparam int QUO_W  = 41;

endpackage
`default_nettype wire

// File: src/piecewise_linear_calibrator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_calibrator_core
// Q16.16 calibration through a table of points with linear interpolation.
// ----------------------------------------------------------------------------
// One item at a time. A load beat (tuser 0) writes one point. An evaluate
// beat (tuser 1) with fewer than two points in use goes straight to the
// output; otherwise it reads the raw table once per step of the segment
// search (up to points_in_use + 1 reads), two reads for the segment ends,
// a multiply (S_MUL0, S_MUL1) and a bit-serial divide; a zero-width segment
// skips the multiply and divide and ends after the segment reads. A finished
// result waits in the output register while the next beat is taken. Table
// entries hold no reset value; keep every point in use loaded.
module piecewise_linear_calibrator_core #(
	parameter int MAX_POINTS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// apb register port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// point_index[3:0], point_raw[35:4], point_mapped[67:36], sample[99:68]
	input  wire logic [103:0] s_tdata,
	// func[0]
	input  wire logic         s_tuser,
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// calibrated[31:0], status[33:32]
	output logic [39:0]       m_tdata
);
	import plc_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int NW = $clog2(MAX_POINTS + 1);

	plc_state_t state_q, state_d;

	logic [4:0]         piu_q;
	logic [31:0]        raw_mem [MAX_POINTS];
	logic [31:0]        map_mem [MAX_POINTS];
	logic [31:0]        raw_rd, map_rd;
	logic [AW-1:0]      rd_addr;

	logic [NW-1:0]      n_q, n_in;
	logic [NW-1:0]      n_m1, n_m2;
	logic [AW-1:0]      i_q, a_q;
	logic [31:0]        x_q, r0_q, m0_q;
	logic [MAG_W-1:0]   dxm_q, dmm_q, drm_q;
	logic               neg_q;
	logic [PROD_W-1:0]  prod_q, prod_sum;
	logic [48:0]        pp0;
	logic [49:0]        pp1;
	logic [31:0]        res_q;
	logic [1:0]         st_q;
	logic [31:0]        ocal_q;
	logic [1:0]         ost_q;
	logic               oval_q;

	logic               s_acc, wr_en;
	logic [3:0]         s_index;
	logic [31:0]        s_raw, s_map, s_sample;
	logic signed [32:0] dx, dm, dr;
	logic               x_le, x_ge, x_lt;
	logic               div_done, div_big;
	logic [QUO_W-1:0]   div_quo, q_sel;
	logic signed [42:0] sum;
	logic               emit;

	assign s_index  = s_tdata[3:0];
	assign s_raw    = s_tdata[35:4];
	assign s_map    = s_tdata[67:36];
	assign s_sample = s_tdata[99:68];

	// register port
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_POINTS_IN_USE) begin
			prdata = {27'd0, piu_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piu_q <= '0;
		end else if (wr_en && paddr[2] == REG_POINTS_IN_USE) begin
			piu_q <= pwdata[4:0];
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// point memories
	always_ff @(posedge clk) begin
		if (s_acc && s_tuser == FUNC_LOAD && 32'(s_index) < MAX_POINTS) begin
			raw_mem[AW'(s_index)] <= s_raw;
			map_mem[AW'(s_index)] <= s_map;
		end
		raw_rd <= raw_mem[rd_addr];
		map_rd <= map_mem[rd_addr];
	end

	assign n_in = (32'(piu_q) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(piu_q);
	assign n_m1 = n_q - NW'(1);
	assign n_m2 = n_q - NW'(2);

	assign x_le = $signed(x_q) <= $signed(raw_rd);
	assign x_ge = $signed(x_q) >= $signed(raw_rd);
	assign x_lt = $signed(x_q) <  $signed(raw_rd);

	assign dx = {x_q[31], x_q} - {r0_q[31], r0_q};
	assign dm = {map_rd[31], map_rd} - {m0_q[31], m0_q};
	assign dr = {raw_rd[31], raw_rd} - {r0_q[31], r0_q};

	assign emit = (state_q == S_OUT) && (!oval_q || m_tready);

	// sequencer
	always_comb begin
		state_d = state_q;
		rd_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_acc && s_tuser == FUNC_EVAL) begin
					state_d = (n_in < NW'(2)) ? S_OUT : S_LOW;
				end
			end
			S_LOW: begin
				if (x_le) begin
					state_d = S_RA;
				end else begin
					rd_addr = n_m1[AW-1:0];
					state_d = S_HIGH;
				end
			end
			S_HIGH: begin
				if (x_ge) begin
					rd_addr = n_m2[AW-1:0];
					state_d = S_RA;
				end else begin
					rd_addr = AW'(1);
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				// x is below the last raw, so the scan always stops by then
				if (x_lt) begin
					rd_addr = i_q - AW'(1);
					state_d = S_RA;
				end else begin
					rd_addr = i_q + AW'(1);
				end
			end
			S_RA: begin
				rd_addr = a_q + AW'(1);
				state_d = S_RB;
			end
			S_RB:   state_d = (dr == '0) ? S_OUT : S_MUL0;
			S_MUL0: state_d = S_MUL1;
			S_MUL1: state_d = S_DIV;
			S_DIV:  state_d = div_done ? S_SUM : S_DIV;
			S_SUM:  state_d = S_OUT;
			S_OUT:  state_d = emit ? S_IDLE : S_OUT;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// partial products, high half of |dm| weighted by 2^16
	assign pp0      = dxm_q * dmm_q[15:0];
	assign pp1      = dxm_q * dmm_q[32:16];
	assign prod_sum = prod_q + {pp1, 16'd0};

	plc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_MUL1),
		.num    (prod_sum),
		.den    (drm_q),
		.done   (div_done),
		.quo    (div_quo),
		.big    (div_big)
	);

	// quotient clamped at 2^40
	assign q_sel = (div_big || div_quo > {1'b1, 40'd0}) ? {1'b1, 40'd0} : div_quo;
	assign sum   = neg_q ? ({{11{m0_q[31]}}, m0_q} - 43'(q_sel))
	                     : ({{11{m0_q[31]}}, m0_q} + 43'(q_sel));

	always_ff @(posedge clk) begin
		if (s_acc) begin
			x_q   <= s_sample;
			n_q   <= n_in;
			res_q <= s_sample;
			st_q  <= ST_PASS;
		end
		if (state_d == S_RA) begin
			a_q <= rd_addr;
		end
		if (state_d == S_SCAN) begin
			i_q <= rd_addr;
		end
		if (state_q == S_RA) begin
			r0_q <= raw_rd;
			m0_q <= map_rd;
		end
		if (state_q == S_RB) begin
			dxm_q <= dx[32] ? MAG_W'(-dx) : MAG_W'(dx);
			dmm_q <= dm[32] ? MAG_W'(-dm) : MAG_W'(dm);
			drm_q <= dr[32] ? MAG_W'(-dr) : MAG_W'(dr);
			neg_q <= dx[32] ^ dm[32] ^ dr[32];
			res_q <= m0_q;
			st_q  <= ST_ZERO;
		end
		if (state_q == S_MUL0) begin
			prod_q <= PROD_W'(pp0);
		end
		if (state_q == S_SUM) begin
			if (sum[42:31] != {12{sum[42]}}) begin
				res_q <= sum[42] ? 32'h8000_0000 : 32'h7fff_ffff;
				st_q  <= ST_SAT;
			end else begin
				res_q <= sum[31:0];
				st_q  <= ST_OK;
			end
		end
		if (emit) begin
			ocal_q <= res_q;
			ost_q  <= st_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (emit) begin
			oval_q <= 1'b1;
		end else if (m_tready) begin
			oval_q <= 1'b0;
		end
	end

	assign m_tvalid = oval_q;
	assign m_tdata  = {6'd0, ost_q, ocal_q};

endmodule
`default_nettype wire

// File: src/plc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plc_div
// Restoring bit-serial divider, one quotient bit per cycle. Keeps the low
// quotient bits plus a sticky flag for any bit shifted out above them.
// ----------------------------------------------------------------------------
module plc_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [plc_pkg::PROD_W-1:0]    num,
	input  wire logic [plc_pkg::MAG_W-1:0]     den,
	output logic                               done,
	output logic [plc_pkg::QUO_W-1:0]          quo,
	output logic                               big
);
	import plc_pkg::*;

	localparam int CW = $clog2(PROD_W + 1);

	logic [PROD_W-1:0] num_q;
	logic [MAG_W-1:0]  den_q;
	logic [MAG_W-1:0]  rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic              big_q;
	logic [CW-1:0]     cnt_q;
	logic              done_q;
	logic [MAG_W:0]    rem_sh;
	logic              fits;

	assign rem_sh = {rem_q, num_q[PROD_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(PROD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			big_q <= 1'b0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[PROD_W-2:0], 1'b0};
			rem_q <= fits ? MAG_W'(rem_sh - {1'b0, den_q}) : rem_sh[MAG_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
			big_q <= big_q | quo_q[QUO_W-1];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign big  = big_q;

endmodule
`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the piecewise linear calibrator: loads tables,
// evaluates samples, and checks each result against a local predictor.
// ----------------------------------------------------------------------------
module testbench;
	import plc_pkg::*;

	typedef struct {
		logic        func;
		logic [3:0]  idx;
		logic [31:0] raw;
		logic [31:0] mapped;
		logic [31:0] smp;
		int          gap;
		logic        cfg;
		logic [4:0]  cfg_val;
	} item_t;

	typedef struct {
		logic [31:0] cal;
		logic [1:0]  st;
	} cal_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         psel = 0, penable = 0, pwrite = 0;
	logic [2:0]   paddr = 0;
	logic [31:0]  pwdata = 0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [103:0] s_tdata = 0;
	logic         s_tuser = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [39:0]  m_tdata;

	piecewise_linear_calibrator_core dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	item_t pending[$];
	cal_t  calib_expected[$];
	longint raw_tab[16];
	longint map_tab[16];
	logic [4:0] tab_count;
	int mismatches = 0;
	int evals = 0, loads = 0, cfg_writes = 0, sat_seen = 0, zero_seen = 0;
	int idle_cycles = 0;
	bit stim_done = 0;

	// segment value, m0 + (x - r0) * dm / dr with truncation and saturation
	function automatic cal_t segment_value(longint x, int a, int b);
		cal_t r;
		longint dx, dm, dr, q, sum;
		logic [127:0] p, quo;
		bit neg;
		dx = x - raw_tab[a];
		dm = map_tab[b] - map_tab[a];
		dr = raw_tab[b] - raw_tab[a];
		if (dr == 0) begin
			r.cal = map_tab[a][31:0];
			r.st = ST_ZERO;
			return r;
		end
		neg = ((dx < 0) != (dm < 0)) != (dr < 0);
		p = 128'(dx < 0 ? -dx : dx) * 128'(dm < 0 ? -dm : dm);
		quo = p / 128'(dr < 0 ? -dr : dr);
		if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
		q = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
		sum = map_tab[a] + q;
		r.st = ST_OK;
		if (sum > 64'sd2147483647) begin
			sum = 64'sd2147483647;
			r.st = ST_SAT;
		end else if (sum < -64'sd2147483648) begin
			sum = -64'sd2147483648;
			r.st = ST_SAT;
		end
		r.cal = sum[31:0];
		return r;
	endfunction

	function automatic cal_t calibrate(logic [31:0] smp);
		cal_t r;
		int n;
		longint x;
		x = longint'($signed(smp));
		n = tab_count > 16 ? 16 : tab_count;
		if (n < 2) begin
			r.cal = smp;
			r.st = ST_PASS;
		end else if (x <= raw_tab[0]) begin
			r = segment_value(x, 0, 1);
		end else if (x >= raw_tab[n-1]) begin
			r = segment_value(x, n - 2, n - 1);
		end else begin
			r.cal = map_tab[n-1][31:0];
			r.st = ST_OK;
			for (int i = 1; i < n; i++) begin
				if (x < raw_tab[i]) begin
					r = segment_value(x, i - 1, i);
					break;
				end
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] rand_word(int mode);
		case (mode)
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 8) << 16;
			default: return $urandom;
		endcase
	endfunction

	function automatic item_t load_item(int i, logic [31:0] r, logic [31:0] m);
		item_t it;
		it.func = FUNC_LOAD;
		it.idx = 4'(i);
		it.raw = r;
		it.mapped = m;
		it.smp = $urandom;
		it.gap = $urandom_range(0, 12);
		it.cfg = 0;
		it.cfg_val = 0;
		return it;
	endfunction

	function automatic item_t eval_item(logic [31:0] s);
		item_t it;
		it = load_item(0, $urandom, $urandom);
		it.func = FUNC_EVAL;
		it.idx = 4'($urandom);
		it.smp = s;
		return it;
	endfunction

	function automatic item_t cfg_item(logic [4:0] v);
		item_t it;
		it = load_item(0, 0, 0);
		it.cfg = 1;
		it.cfg_val = v;
		return it;
	endfunction

	// ascending table of n points with a chosen raw spread
	task automatic queue_table(int n, int spread);
		logic [31:0] r, step;
		r = $urandom_range(0, 3) == 0 ? 32'h80000000 : ($urandom & 32'hf000ffff) - 32'h08000000;
		for (int i = 0; i < n; i++) begin
			pending.push_back(load_item(i, r,
				$urandom_range(0, 5) == 0 ? rand_word($urandom_range(0, 1)) : $urandom));
			step = spread == 0 ? $urandom_range(0, 1) << 16 : $urandom_range(0, spread) << 12;
			if ($signed(r) > 0 && $signed(r + step) < 0) step = 0;
			r = r + step;
		end
	endtask

	// driver
	int gap_left = 0;
	bit apb_phase = 0;
	bit drain_wait = 0;
	int drain_cnt = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				s_tvalid <= 0;
			end else if (psel) begin
				if (!penable) begin
					penable <= 1;
				end else begin
					psel <= 0;
					penable <= 0;
					pwrite <= 0;
					tab_count = pwdata[4:0];
					cfg_writes++;
				end
			end else if (!s_tvalid && pending.size() > 0) begin
				if (pending[0].cfg) begin
					// wait for the block to settle before touching the register
					if (calib_expected.size() != 0) begin
						drain_cnt <= 0;
					end else if (drain_cnt < 100) begin
						drain_cnt <= drain_cnt + 1;
					end else begin
						drain_cnt <= 0;
						psel <= 1;
						pwrite <= 1;
						paddr <= {REG_POINTS_IN_USE, 2'b00};
						pwdata <= {27'd0, pending[0].cfg_val};
						void'(pending.pop_front());
					end
				end else if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else begin
					s_tvalid <= 1;
					s_tuser <= pending[0].func;
					s_tdata <= {4'd0, pending[0].smp, pending[0].mapped,
						pending[0].raw, pending[0].idx};
					gap_left <= pending[0].gap;
					if (pending[0].func == FUNC_LOAD) begin
						raw_tab[pending[0].idx] = longint'($signed(pending[0].raw));
						map_tab[pending[0].idx] = longint'($signed(pending[0].mapped));
						loads++;
					end else begin
						calib_expected.push_back(calibrate(pending[0].smp));
						evals++;
					end
					void'(pending.pop_front());
				end
			end
		end
	end

	// monitor
	int stall_left = 0;
	always @(posedge clk) begin
		cal_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (calib_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat %h", m_tdata);
				end else begin
					e = calib_expected.pop_front();
					if (e.st == ST_SAT) sat_seen++;
					if (e.st == ST_ZERO) zero_seen++;
					if (m_tdata[31:0] !== e.cal || m_tdata[33:32] !== e.st) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected cal %h st %0d, got cal %h st %0d",
								e.cal, e.st, m_tdata[31:0], m_tdata[33:32]);
					end
				end
				m_tready <= 0;
				stall_left <= $urandom_range(0, 12);
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
			end else begin
				m_tready <= 1;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles > 20000) begin
			$display("watchdog expired with %0d results outstanding", calib_expected.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int n;
		tab_count = 0;
		for (int i = 0; i < 16; i++) begin
			raw_tab[i] = 0;
			map_tab[i] = 0;
		end
		// directed: passthrough with no points, then with one point, then two- and four-point tables
		pending.push_back(eval_item(32'h7fffffff));
		pending.push_back(eval_item(32'h80000000));
		pending.push_back(load_item(0, 32'h00010000, 32'h00020000));
		pending.push_back(load_item(1, 32'h00030000, 32'h00060000));
		pending.push_back(load_item(2, 32'h00030000, 32'h7fff0000));
		pending.push_back(load_item(3, 32'h00050000, 32'h80000000));
		pending.push_back(cfg_item(1));
		pending.push_back(eval_item(32'h00020000));
		pending.push_back(cfg_item(2));
		pending.push_back(eval_item(32'h00020000));
		pending.push_back(eval_item(32'h80000000));
		pending.push_back(eval_item(32'h7fffffff));
		pending.push_back(eval_item(32'h00010000));
		pending.push_back(cfg_item(4));
		pending.push_back(eval_item(32'h00030000));
		pending.push_back(eval_item(32'h00040000));
		pending.push_back(eval_item(32'h7fffffff));
		pending.push_back(eval_item(32'h00028000));
		// random phases: a full table is loaded each time, then a mixed number of points is put in use
		while (pending.size() < 1100) begin
			n = $urandom_range(0, 3) == 0 ? 16 : $urandom_range(2, 16);
			if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 1);
			queue_table(16, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 4000));
			pending.push_back(cfg_item($urandom_range(0, 5) == 0 ? 5'd31 : 5'(n)));
			repeat ($urandom_range(10, 30))
				pending.push_back(eval_item($urandom_range(0, 3) == 0 ?
					rand_word($urandom_range(0, 1)) : $urandom));
		end
		pending.push_back(cfg_item(16));
		pending.push_back(eval_item(32'h00000000));
		pending.push_back(cfg_item(0));
		pending.push_back(eval_item(32'h12345678));
		stim_done = 1;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		wait (stim_done);
		while (pending.size() > 0 || s_tvalid || psel || calib_expected.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d loads, %0d evaluations, %0d register writes", loads, evals,
			cfg_writes);
		$display("saturated results %0d, zero-width results %0d, mismatches %0d",
			sat_seen, zero_seen, mismatches);
		if (mismatches == 0 && calib_expected.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
